// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the page framebuffer draw engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: hw/rtl/pfde_pkg.sv
// Shared constants, codes and word types of the page framebuffer draw engine.
package pfde_pkg;

    localparam int PANEL_WIDTH  = 256;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGES        = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = PANEL_WIDTH * PAGES;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int MAX_DIM      = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CO_W         = $clog2(MAX_DIM);
    localparam int CNT_W        = $clog2(MAX_DIM + 1);
    localparam int GW           = 19;

    localparam logic [2:0] OP_PIXEL  = 3'd0;
    localparam logic [2:0] OP_HLINE  = 3'd1;
    localparam logic [2:0] OP_VLINE  = 3'd2;
    localparam logic [2:0] OP_RDPIX  = 3'd3;
    localparam logic [2:0] OP_RDBYTE = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [1:0] COL_CLEAR = 2'd0;
    localparam logic [1:0] COL_SET   = 2'd1;
    localparam logic [1:0] COL_INV   = 2'd2;
    localparam logic [1:0] COL_KEEP  = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic signed [15:0] length;
        logic [1:0]         color;
        logic [10:0]        byte_index;
    } t_in_word;

    typedef struct packed {
        logic       pixel_value;
        logic [7:0] byte_value;
    } t_out_word;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        color;
        logic              draw;
        logic              vert;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        logic [2:0]        lo;
        logic [2:0]        hi;
        logic              byte_ok;
        logic [ADDR_W-1:0] baddr;
    } t_job;

    typedef struct packed {
        logic start;
        logic res_ready;
    } t_eng_ctl;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_sts;

endpackage

// File: hw/rtl/pfde_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module pfde_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pfde_geom.sv
// Rotation mapping, clipping and address setup pipeline for one drawing request.
module pfde_geom import pfde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_in_word   i_word,
    input  logic [1:0] i_rotation,
    output logic       o_job_valid,
    output t_job       o_job
);

    localparam logic signed [GW-1:0] WC  = GW'(PANEL_WIDTH);
    localparam logic signed [GW-1:0] HC  = GW'(PANEL_HEIGHT);
    localparam logic signed [GW-1:0] ONE = GW'(1);

    logic signed [GW-1:0] x_s;
    logic signed [GW-1:0] y_s;
    logic signed [GW-1:0] l_s;
    logic signed [GW-1:0] n_a_fix;
    logic signed [GW-1:0] n_a_start;
    logic                 n_a_vert;

    logic                 r_a_valid;
    logic [2:0]           r_a_op;
    logic [1:0]           r_a_color;
    logic [10:0]          r_a_bidx;
    logic                 r_a_vert;
    logic signed [GW-1:0] r_a_fix;
    logic signed [GW-1:0] r_a_start;
    logic signed [GW-1:0] r_a_n;

    logic                 n_b_fix_ok;
    logic signed [GW-1:0] n_b_start;
    logic signed [GW-1:0] n_b_n;

    logic                 r_b_valid;
    logic [2:0]           r_b_op;
    logic [1:0]           r_b_color;
    logic [10:0]          r_b_bidx;
    logic                 r_b_vert;
    logic                 r_b_fix_ok;
    logic signed [GW-1:0] r_b_fix;
    logic signed [GW-1:0] r_b_start;
    logic signed [GW-1:0] r_b_n;

    logic signed [GW-1:0] c_lim;
    logic signed [GW-1:0] c_sum;
    logic signed [GW-1:0] n_c_n;

    logic                 r_c_valid;
    logic [2:0]           r_c_op;
    logic [1:0]           r_c_color;
    logic [10:0]          r_c_bidx;
    logic                 r_c_vert;
    logic                 r_c_draw;
    logic signed [GW-1:0] r_c_fix;
    logic signed [GW-1:0] r_c_start;
    logic signed [GW-1:0] r_c_n;

    logic signed [GW-1:0] d_end_g;
    logic [CO_W-1:0]      d_start;
    logic [CO_W-1:0]      d_fix;
    logic [CO_W-1:0]      d_end;
    logic [CO_W-1:0]      d_spage;
    logic [CO_W-1:0]      d_epage;
    logic [CO_W-1:0]      d_fpage;
    t_job                 n_job;

    logic                 r_job_valid;
    t_job                 r_job;

    assign x_s = GW'(i_word.x_coord);
    assign y_s = GW'(i_word.y_coord);
    assign l_s = (i_word.operation == OP_HLINE || i_word.operation == OP_VLINE) ?
                 GW'(i_word.length) : ONE;

    always_comb begin
        n_a_vert  = 1'b0;
        n_a_fix   = y_s;
        n_a_start = x_s;
        if (i_word.operation != OP_VLINE) begin
            case (i_rotation)
                2'd1: begin
                    n_a_vert  = 1'b1;
                    n_a_fix   = WC - ONE - y_s;
                    n_a_start = x_s;
                end
                2'd2: begin
                    n_a_vert  = 1'b0;
                    n_a_fix   = HC - ONE - y_s;
                    n_a_start = WC - x_s - l_s;
                end
                2'd3: begin
                    n_a_vert  = 1'b1;
                    n_a_fix   = y_s;
                    n_a_start = HC - x_s - l_s;
                end
                default: begin
                    n_a_vert  = 1'b0;
                    n_a_fix   = y_s;
                    n_a_start = x_s;
                end
            endcase
        end else begin
            case (i_rotation)
                2'd1: begin
                    n_a_vert  = 1'b0;
                    n_a_fix   = x_s;
                    n_a_start = WC - y_s - l_s;
                end
                2'd2: begin
                    n_a_vert  = 1'b1;
                    n_a_fix   = WC - ONE - x_s;
                    n_a_start = HC - y_s - l_s;
                end
                2'd3: begin
                    n_a_vert  = 1'b0;
                    n_a_fix   = HC - ONE - x_s;
                    n_a_start = y_s;
                end
                default: begin
                    n_a_vert  = 1'b1;
                    n_a_fix   = x_s;
                    n_a_start = y_s;
                end
            endcase
        end
    end

    always_comb begin
        n_b_fix_ok = (r_a_fix >= 0) && (r_a_fix < (r_a_vert ? WC : HC));
        if (r_a_start < 0) begin
            n_b_n     = r_a_n + r_a_start;
            n_b_start = '0;
        end else begin
            n_b_n     = r_a_n;
            n_b_start = r_a_start;
        end
    end

    assign c_lim = r_b_vert ? HC : WC;
    assign c_sum = r_b_start + r_b_n;
    assign n_c_n = (c_sum > c_lim) ? (c_lim - r_b_start) : r_b_n;

    assign d_end_g = r_c_start + r_c_n - ONE;
    assign d_start = r_c_start[CO_W-1:0];
    assign d_fix   = r_c_fix[CO_W-1:0];
    assign d_end   = d_end_g[CO_W-1:0];
    assign d_spage = d_start >> 3;
    assign d_epage = d_end >> 3;
    assign d_fpage = d_fix >> 3;

    always_comb begin
        n_job.op      = r_c_op;
        n_job.color   = r_c_color;
        n_job.draw    = r_c_draw;
        n_job.vert    = r_c_vert;
        n_job.byte_ok = 32'(r_c_bidx) < 32'(STORE_BYTES);
        n_job.baddr   = ADDR_W'(r_c_bidx);
        if (r_c_vert) begin
            n_job.addr  = ADDR_W'(32'(d_spage) * PANEL_WIDTH + 32'(d_fix));
            n_job.count = CNT_W'(d_epage - d_spage) + CNT_W'(1);
            n_job.lo    = d_start[2:0];
            n_job.hi    = d_end[2:0];
        end else begin
            n_job.addr  = ADDR_W'(32'(d_fpage) * PANEL_WIDTH + 32'(d_start));
            n_job.count = r_c_n[CNT_W-1:0];
            n_job.lo    = d_fix[2:0];
            n_job.hi    = d_fix[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            r_a_valid   <= i_start;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_job_valid <= r_c_valid;
        end
        if (i_start) begin
            r_a_op    <= i_word.operation;
            r_a_color <= i_word.color;
            r_a_bidx  <= i_word.byte_index;
            r_a_vert  <= n_a_vert;
            r_a_fix   <= n_a_fix;
            r_a_start <= n_a_start;
            r_a_n     <= l_s;
        end
        r_b_op     <= r_a_op;
        r_b_color  <= r_a_color;
        r_b_bidx   <= r_a_bidx;
        r_b_vert   <= r_a_vert;
        r_b_fix_ok <= n_b_fix_ok;
        r_b_fix    <= r_a_fix;
        r_b_start  <= n_b_start;
        r_b_n      <= n_b_n;
        r_c_op     <= r_b_op;
        r_c_color  <= r_b_color;
        r_c_bidx   <= r_b_bidx;
        r_c_vert   <= r_b_vert;
        r_c_draw   <= r_b_fix_ok && (n_c_n > 0);
        r_c_fix    <= r_b_fix;
        r_c_start  <= r_b_start;
        r_c_n      <= n_c_n;
        r_job      <= n_job;
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

// File: hw/rtl/pfde_engine.sv
// Read-modify-write sequencer that owns the frame store, its clearing pass and reads.
module pfde_engine import pfde_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_eng_ctl  i_ctl,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output t_eng_sts  o_sts,
    output t_out_word o_res
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GEOM,
        S_RUN,
        S_FLUSH,
        S_RDPIX,
        S_RDBYTE,
        S_DONE
    } t_state;

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(PANEL_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    t_state            r_state;
    logic [ADDR_W-1:0] r_addr;
    logic              r_vert;
    logic [CNT_W-1:0]  r_count;
    logic              r_first;
    logic [2:0]        r_lo;
    logic [2:0]        r_hi;
    logic [1:0]        r_color;
    logic              r_wvalid;
    logic [ADDR_W-1:0] r_waddr;
    logic [7:0]        r_wmask;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_op;
    logic [2:0]        r_rd_bit;
    t_out_word         r_res;

    logic              last;
    logic [2:0]        lo_eff;
    logic [2:0]        hi_eff;
    logic [7:0]        mask;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    function automatic logic [7:0] paint(input logic [7:0] data, input logic [7:0] m,
                                         input logic [1:0] color);
        logic [7:0] res;
        case (color)
            COL_CLEAR: res = data & ~m;
            COL_SET:   res = data | m;
            COL_INV:   res = data ^ m;
            default:   res = data;
        endcase
        return res;
    endfunction

    assign last   = (r_count == CNT_W'(1));
    assign lo_eff = (r_first || !r_vert) ? r_lo : 3'd0;
    assign hi_eff = (last || !r_vert) ? r_hi : 3'd7;
    assign mask   = (8'hFF << lo_eff) & (8'hFF >> (3'd7 - hi_eff));

    assign rd_addr = (r_state == S_RUN) ? r_addr :
                     ((i_job.op == OP_RDBYTE) ? i_job.baddr : i_job.addr);

    assign mem_we    = r_wvalid || (r_state == S_CLEAR);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_waddr;
    assign mem_wdata = (r_state == S_CLEAR) ? 8'h00 : paint(rd_data, r_wmask, r_color);

    pfde_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_op   <= 1'b0;
            r_wvalid   <= 1'b0;
        end else begin
            r_wvalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_res   <= '0;
                        r_state <= r_clr_op ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= S_GEOM;
                    end
                end
                S_GEOM: begin
                    if (i_job_valid) begin
                        r_res <= '0;
                        case (i_job.op)
                            OP_PIXEL, OP_HLINE, OP_VLINE: begin
                                r_addr  <= i_job.addr;
                                r_vert  <= i_job.vert;
                                r_count <= i_job.count;
                                r_first <= 1'b1;
                                r_lo    <= i_job.lo;
                                r_hi    <= i_job.hi;
                                r_color <= i_job.color;
                                if (i_job.draw && i_job.color != COL_KEEP) begin
                                    r_state <= S_RUN;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            OP_RDPIX: begin
                                r_rd_bit <= i_job.lo;
                                r_state  <= i_job.draw ? S_RDPIX : S_DONE;
                            end
                            OP_RDBYTE: begin
                                r_state <= i_job.byte_ok ? S_RDBYTE : S_DONE;
                            end
                            OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_op   <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_wvalid <= 1'b1;
                    r_waddr  <= r_addr;
                    r_wmask  <= mask;
                    r_addr   <= r_vert ? (r_addr + ROW_STEP) : (r_addr + ADDR_W'(1));
                    r_count  <= r_count - CNT_W'(1);
                    r_first  <= 1'b0;
                    if (last) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_DONE;
                end
                S_RDPIX: begin
                    r_res.pixel_value <= rd_data[r_rd_bit];
                    r_state           <= S_DONE;
                end
                S_RDBYTE: begin
                    r_res.byte_value <= rd_data;
                    r_state          <= S_DONE;
                end
                S_DONE: begin
                    if (i_ctl.res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.idle      = (r_state == S_IDLE);
    assign o_sts.res_valid = (r_state == S_DONE);
    assign o_res           = r_res;

endmodule

// File: hw/rtl/page_framebuffer_draw_engine_top.sv
// Top level of the page framebuffer draw engine: handshakes, rotation register, result register.
// A clear writes one store byte per cycle, and one item is in work at a time.
// After reset the store is swept to zero with the input ready held low.
`include "assert_macros.svh"

module page_framebuffer_draw_engine_top import pfde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data
);

    logic [1:0] r_rotation;
    logic       r_out_valid;
    t_out_word  r_out_word;

    logic       accept;
    logic       job_valid;
    t_job       job;
    t_eng_ctl   eng_ctl;
    t_eng_sts   eng_sts;
    t_out_word  eng_res;

    assign accept            = i_in_valid && eng_sts.idle;
    assign eng_ctl.start     = accept;
    assign eng_ctl.res_ready = !r_out_valid || i_out_ready;

    pfde_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_word      (i_in_word),
        .i_rotation  (r_rotation),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    pfde_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (eng_ctl),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_sts       (eng_sts),
        .o_res       (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation  <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rotation <= i_cfg_wr_data;
            end
            if (eng_sts.res_valid && eng_ctl.res_ready) begin
                r_out_valid <= 1'b1;
                r_out_word  <= eng_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = eng_sts.idle;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_ALWAYS(a_busy_after_accept, i_clk, i_rst_n, accept |=> !eng_sts.idle, "Input still ready after an accept.")
    `ASSERT_ALWAYS(a_result_lands, i_clk, i_rst_n, (eng_sts.res_valid && eng_ctl.res_ready) |=> r_out_valid, "Finished word did not reach the output register.")
    `ASSERT_NEVER(a_job_while_idle, i_clk, i_rst_n, job_valid && eng_sts.idle, "Geometry job arrived with no item in work.")

endmodule

// File: dv/tb_page_framebuffer_draw_engine_top.sv
// Self-checking testbench for the page framebuffer draw engine top level.
module tb_page_framebuffer_draw_engine_top;
    import pfde_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam logic [1:0] ROT_NONE          = 2'd0;
    localparam logic [1:0] ROT_QUARTER       = 2'd1;
    localparam logic [1:0] ROT_HALF          = 2'd2;
    localparam logic [1:0] ROT_THREE_QUARTER = 2'd3;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int IDLE_PERCENT = 7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_word  out_word;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;

    logic [7:0] frame_mem [STORE_BYTES];
    logic [1:0] rotation_cfg = ROT_NONE;
    t_out_word  readback_q [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         ready_hold = 0;
    bit         calm_run = 1'b0;

    always #1 clk = ~clk;

    page_framebuffer_draw_engine_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_word     (in_word),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_word    (out_word),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    function automatic void paint_pixel(int col, int row, logic [1:0] color);
        int         idx;
        logic [7:0] bitmask;
        idx = (row >>> 3) * PANEL_WIDTH + col;
        bitmask = 8'd1 << (row & 7);
        if (idx < 0 || idx >= STORE_BYTES) return;
        case (color)
            COL_SET:   frame_mem[idx] = frame_mem[idx] | bitmask;
            COL_CLEAR: frame_mem[idx] = frame_mem[idx] & ~bitmask;
            COL_INV:   frame_mem[idx] = frame_mem[idx] ^ bitmask;
            default: ;
        endcase
    endfunction

    function automatic void draw_row_span(int x, int y, int w, logic [1:0] color);
        if (y < 0 || y >= PANEL_HEIGHT) return;
        if (x < 0) begin
            w = w + x;
            x = 0;
        end
        if (x + w > PANEL_WIDTH) w = PANEL_WIDTH - x;
        for (int i = 0; i < w; i++) paint_pixel(x + i, y, color);
    endfunction

    function automatic void draw_column_span(int x, int y, int h, logic [1:0] color);
        if (x < 0 || x >= PANEL_WIDTH) return;
        if (y < 0) begin
            h = h + y;
            y = 0;
        end
        if (y + h > PANEL_HEIGHT) h = PANEL_HEIGHT - y;
        for (int i = 0; i < h; i++) paint_pixel(x, y + i, color);
    endfunction

    function automatic bit map_logical(int x, int y, output int px, output int py);
        int lw;
        int lh;
        lw = rotation_cfg[0] ? PANEL_HEIGHT : PANEL_WIDTH;
        lh = rotation_cfg[0] ? PANEL_WIDTH : PANEL_HEIGHT;
        px = 0;
        py = 0;
        if (x < 0 || x >= lw || y < 0 || y >= lh) return 1'b0;
        case (rotation_cfg)
            ROT_QUARTER: begin
                px = PANEL_WIDTH - y - 1;
                py = x;
            end
            ROT_HALF: begin
                px = PANEL_WIDTH - x - 1;
                py = PANEL_HEIGHT - y - 1;
            end
            ROT_THREE_QUARTER: begin
                px = y;
                py = PANEL_HEIGHT - x - 1;
            end
            default: begin
                px = x;
                py = y;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic t_out_word compute_readback(t_in_word w);
        t_out_word res;
        int        x;
        int        y;
        int        len;
        int        px;
        int        py;
        x = int'(w.x_coord);
        y = int'(w.y_coord);
        len = int'(w.length);
        res = '0;
        case (w.operation)
            OP_PIXEL: begin
                if (map_logical(x, y, px, py)) paint_pixel(px, py, w.color);
            end
            OP_HLINE: begin
                case (rotation_cfg)
                    ROT_QUARTER:
                        draw_column_span(PANEL_WIDTH - y - 1, x, len, w.color);
                    ROT_THREE_QUARTER:
                        draw_column_span(y, PANEL_HEIGHT - x - 1 - (len - 1), len, w.color);
                    ROT_HALF:
                        draw_row_span(PANEL_WIDTH - x - 1 - (len - 1), PANEL_HEIGHT - y - 1,
                                      len, w.color);
                    default:
                        draw_row_span(x, y, len, w.color);
                endcase
            end
            OP_VLINE: begin
                case (rotation_cfg)
                    ROT_QUARTER:
                        draw_row_span(PANEL_WIDTH - y - 1 - (len - 1), x, len, w.color);
                    ROT_THREE_QUARTER:
                        draw_row_span(y, PANEL_HEIGHT - x - 1, len, w.color);
                    ROT_HALF:
                        draw_column_span(PANEL_WIDTH - x - 1, PANEL_HEIGHT - y - 1 - (len - 1),
                                         len, w.color);
                    default:
                        draw_column_span(x, y, len, w.color);
                endcase
            end
            OP_RDPIX: begin
                if (map_logical(x, y, px, py))
                    res.pixel_value = frame_mem[(py >>> 3) * PANEL_WIDTH + px][py & 7];
            end
            OP_RDBYTE: begin
                if (int'(w.byte_index) < STORE_BYTES) res.byte_value = frame_mem[w.byte_index];
            end
            OP_CLEAR: begin
                foreach (frame_mem[i]) frame_mem[i] = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in_word pack_command(logic [2:0] op, int x, int y, int len,
                                              logic [1:0] color, int idx);
        t_in_word w;
        w.operation  = op;
        w.x_coord    = 16'(x);
        w.y_coord    = 16'(y);
        w.length     = 16'(len);
        w.color      = color;
        w.byte_index = 11'(idx);
        return w;
    endfunction

    function automatic t_in_word random_command();
        t_in_word w;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)      w.operation = OP_PIXEL;
        else if (pick < 38) w.operation = OP_HLINE;
        else if (pick < 56) w.operation = OP_VLINE;
        else if (pick < 72) w.operation = OP_RDPIX;
        else if (pick < 93) w.operation = OP_RDBYTE;
        else if (pick < 95) w.operation = OP_CLEAR;
        else                w.operation = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        w.x_coord    = 16'(($urandom_range(0, 9) == 0) ? $urandom
                                                        : $urandom_range(0, 340) - 40);
        w.y_coord    = 16'(($urandom_range(0, 9) == 0) ? $urandom
                                                        : $urandom_range(0, 340) - 40);
        w.length     = 16'(($urandom_range(0, 9) == 0) ? $urandom
                                                        : $urandom_range(0, 308) - 8);
        w.color      = 2'($urandom_range(0, 3));
        w.byte_index = 11'($urandom_range(0, 2047));
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        if (!calm_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        readback_q.push_back(compute_readback(w));
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_word(random_command());
    endtask

    task automatic drain_readbacks();
        in_valid <= 1'b0;
        while (readback_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_rotation(input logic [1:0] rot);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rot;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        rotation_cfg = rot;
    endtask

    task automatic test_directed_cases();
        send_word(pack_command(OP_PIXEL, 0, 0, 0, COL_SET, 0));
        send_word(pack_command(OP_PIXEL, 255, 63, 0, COL_SET, 0));
        send_word(pack_command(OP_RDPIX, 0, 0, 0, COL_KEEP, 0));
        send_word(pack_command(OP_RDPIX, 255, 63, 0, COL_KEEP, 0));
        send_word(pack_command(OP_RDBYTE, 0, 0, 0, COL_KEEP, 0));
        send_word(pack_command(OP_RDBYTE, 0, 0, 0, COL_KEEP, 2047));
        send_word(pack_command(OP_PIXEL, -32768, 32767, -32768, COL_SET, 1365));
        send_word(pack_command(OP_RDPIX, 32767, -1, 32767, COL_KEEP, 682));
        send_word(pack_command(OP_HLINE, -32768, 5, 32767, COL_SET, 0));
        send_word(pack_command(OP_HLINE, -10, 9, 300, COL_INV, 0));
        send_word(pack_command(OP_HLINE, 100, 64, 10, COL_SET, 0));
        send_word(pack_command(OP_HLINE, 10, 3, -32768, COL_SET, 0));
        send_word(pack_command(OP_VLINE, 7, -3, 32767, COL_SET, 0));
        send_word(pack_command(OP_VLINE, 20, 3, 19, COL_SET, 0));
        send_word(pack_command(OP_VLINE, 7, 2, 40, COL_KEEP, 0));
        send_word(pack_command(OP_VLINE, 7, 10, 5, COL_CLEAR, 0));
        send_word(pack_command(OP_RDBYTE, 0, 0, 0, COL_KEEP, 7));
        send_word(pack_command(OP_RDBYTE, 0, 0, 0, COL_KEEP, 263));
        send_word(pack_command(OP_RDBYTE, 0, 0, 0, COL_KEEP, 276));
        send_word(pack_command(OP_SPARE_A, 1, 1, 8, COL_SET, 7));
        send_word(pack_command(OP_SPARE_B, -1, -1, -1, COL_INV, 1047));
        send_word(pack_command(OP_RDPIX, 20, 4, 0, COL_KEEP, 0));
        send_word(pack_command(OP_CLEAR, 0, 0, 0, COL_SET, 0));
        send_word(pack_command(OP_RDBYTE, 0, 0, 0, COL_KEEP, 7));
        send_word(pack_command(OP_PIXEL, 3, 3, 0, COL_INV, 0));
        send_word(pack_command(OP_PIXEL, 3, 3, 0, COL_KEEP, 0));
        send_word(pack_command(OP_RDPIX, 3, 3, 0, COL_KEEP, 0));
        drain_readbacks();
    endtask

    task automatic test_rotation_sweep();
        for (int r = 0; r < 4; r++) begin
            write_rotation(r[1:0]);
            send_random(70);
            drain_readbacks();
        end
    endtask

    task automatic test_output_backpressure();
        write_rotation(ROT_THREE_QUARTER);
        ready_hold = 400;
        send_random(40);
        drain_readbacks();
    endtask

    task automatic test_paused_sender();
        write_rotation(ROT_QUARTER);
        send_random(20);
        drain_readbacks();
        send_random(20);
        drain_readbacks();
    endtask

    task automatic test_steady_stream();
        write_rotation(ROT_HALF);
        calm_run = 1'b1;
        send_random(40);
        drain_readbacks();
        calm_run = 1'b0;
    endtask

    initial begin : readback_checker
        t_out_word want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (readback_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result word with none outstanding: pixel %0b byte %02h",
                                 out_word.pixel_value, out_word.byte_value);
                end else begin
                    want = readback_q.pop_front();
                    if (out_word.pixel_value !== want.pixel_value ||
                        out_word.byte_value !== want.byte_value) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Result mismatch: expected pixel %0b byte %02h, got pixel %0b byte %02h",
                                     want.pixel_value, want.byte_value,
                                     out_word.pixel_value, out_word.byte_value);
                    end
                end
            end
            if (ready_hold > 0) begin
                out_ready <= 1'b0;
                ready_hold--;
            end else begin
                out_ready <= calm_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("page_framebuffer_draw_engine_top verification failed");
        $finish;
    end

    initial begin : test_sequence
        foreach (frame_mem[i]) frame_mem[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_rotation(ROT_NONE);
        test_directed_cases();
        test_rotation_sweep();
        test_output_backpressure();
        test_paused_sender();
        test_steady_stream();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("page_framebuffer_draw_engine_top verification clean");
        end else begin
            $display("page_framebuffer_draw_engine_top verification failed");
        end
        $finish;
    end

endmodule
